// File: sv/avrg_pkg.sv
// Shared types and constants of the attribute raster generator.
package avrg_pkg;

  localparam int unsigned AVRG_COLUMN_LAST  = 447;
  localparam int unsigned AVRG_LINE_LAST    = 311;
  localparam int unsigned AVRG_ATTR_ENTRIES = 768;

  localparam int CNT_W  = 9;
  localparam int ADDR_W = 10;

  localparam logic [CNT_W-1:0] COL_FETCH_FIRST  = 9'd256;
  localparam logic [CNT_W-1:0] COL_BORDER_FIRST = 9'd288;
  localparam logic [CNT_W-1:0] COL_TRIGGER      = 9'd319;
  localparam logic [CNT_W-1:0] COL_INT_END      = 9'd32;
  localparam logic [CNT_W-1:0] LINE_ACTIVE      = 9'd192;
  localparam logic [CNT_W-1:0] LINE_VSYNC_LOW   = 9'd248;
  localparam logic [CNT_W-1:0] LINE_VSYNC_HIGH  = 9'd252;
  localparam logic [CNT_W-1:0] BORDER_WORD_BASE = 9'd256;

  localparam logic [7:0] TEST_BITMAP_RESET = 8'd170;

  typedef enum logic [1:0] {
    SLOT_NONE     = 2'd0,
    SLOT_PIXEL    = 2'd1,
    SLOT_BORDER   = 2'd2,
    SLOT_TEMPLATE = 2'd3
  } slot_kind_t;

  typedef enum logic {
    ACT_TICK       = 1'b0,
    ACT_ATTR_WRITE = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [9:0]  attr_addr;
    logic [7:0]  attr_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  slot_kind;
    logic [8:0]  word_index;
    logic [3:0]  colour_index;
    logic [3:0]  rgb_bits;
    logic        buffer_select;
    logic        line_trigger;
    logic        int_level;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  test_bitmap;
  } cfg_item_t;

  // One tick's job, handed from the counter stage to the result sequencer.
  typedef struct packed {
    slot_kind_t  kind;       // SLOT_NONE, SLOT_PIXEL, or SLOT_BORDER for a border/template group
    logic [4:0]  group;
    logic [7:0]  bitmap;
    logic        flash_on;
    logic        buffer_select;
    logic        line_trigger;
    logic        int_level;
  } job_t;

endpackage

// File: sv/avrg_chan_if.sv
// Valid/ready channel carrying one payload item.
interface avrg_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/attribute_video_raster_generator.sv
// Top level of the attribute-colour raster generator.
//
//   channel  dir  payload                                   transaction
//   din      in   action, attr_addr, attr_data              tick or attribute write
//   cfg      in   test_bitmap                               register write
//   dout     out  slot_kind .. last (one result)            one result word
//
// A fetch tick yields eight results, a border tick four, any other tick one;
// the sequencer delivers one result per cycle while dout is ready.
// The attribute store is read the cycle a fetch tick is taken; the job then
// waits in a single register while the previous tick drains.
// Attribute writes give no result. Reset is synchronous.
// Stalls on dout hold the result register; din stalls only when the job register is full.
module attribute_video_raster_generator
  import avrg_pkg::*;
#(
  parameter int unsigned COLUMN_LAST  = AVRG_COLUMN_LAST,
  parameter int unsigned LINE_LAST    = AVRG_LINE_LAST,
  parameter int unsigned ATTR_ENTRIES = AVRG_ATTR_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  avrg_chan_if.sink   din,
  avrg_chan_if.sink   cfg,
  avrg_chan_if.source dout
);

  localparam int AW = $clog2(ATTR_ENTRIES);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          job_valid;
  job_t          job;
  logic          job_take;

  avrg_ram #(
    .WIDTH (8),
    .DEPTH (ATTR_ENTRIES)
  ) u_attr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  avrg_ctrl #(
    .COLUMN_LAST  (COLUMN_LAST),
    .LINE_LAST    (LINE_LAST),
    .ATTR_ENTRIES (ATTR_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  avrg_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .job_take   (job_take),
    .attr_rdata (ram_rdata),
    .dout       (dout)
  );

endmodule

// File: sv/avrg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module avrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/avrg_ctrl.sv
// Raster counters, attribute store access and the job register.
module avrg_ctrl
  import avrg_pkg::*;
#(
  parameter int unsigned COLUMN_LAST  = AVRG_COLUMN_LAST,
  parameter int unsigned LINE_LAST    = AVRG_LINE_LAST,
  parameter int unsigned ATTR_ENTRIES = AVRG_ATTR_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  avrg_chan_if.sink                       din,
  avrg_chan_if.sink                       cfg,
  output logic                            ram_we,
  output logic [$clog2(ATTR_ENTRIES)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(ATTR_ENTRIES)-1:0] ram_raddr,
  output logic                            job_valid,
  output job_t                            job,
  input  logic                            job_take
);

  localparam int AW = $clog2(ATTR_ENTRIES);

  logic [CNT_W-1:0] hc;
  logic [CNT_W-1:0] vc;
  logic             int_state;
  logic [7:0]       flash_count;
  logic             vsync_state;
  logic             active_buffer;
  logic [7:0]       test_bitmap;

  logic             accept;
  logic             tick;
  logic             is_fetch;
  logic             is_border;
  logic             trig;
  logic             nv;
  logic [CNT_W-1:0] hc_next;
  logic [CNT_W-1:0] vc_next;
  logic             int_next;
  logic [ADDR_W-1:0] aidx;
  job_t             job_next;

  assign din.ready = !job_valid || job_take;
  assign cfg.ready = 1'b1;
  assign accept    = din.valid && din.ready;
  assign tick      = accept && (din.data.action == ACT_TICK);

  assign is_fetch  = (hc >= COL_FETCH_FIRST) && (hc < COL_BORDER_FIRST) && (vc < LINE_ACTIVE);
  assign is_border = (hc >= COL_BORDER_FIRST) && (hc <= COL_TRIGGER);
  assign trig      = (hc == COL_TRIGGER);

  // Eight lines share one row of 32 attributes.
  assign aidx = {vc[7:3], hc[4:0]};

  assign ram_we    = accept && (din.data.action == ACT_ATTR_WRITE)
                     && (din.data.attr_addr < ADDR_W'(ATTR_ENTRIES));
  assign ram_waddr = din.data.attr_addr[AW-1:0];
  assign ram_wdata = din.data.attr_data;
  assign ram_re    = tick && is_fetch;
  assign ram_raddr = aidx[AW-1:0];

  always_comb begin
    if (hc == CNT_W'(COLUMN_LAST)) begin
      hc_next = '0;
      vc_next = (vc == CNT_W'(LINE_LAST)) ? '0 : vc + 1'b1;
    end else begin
      hc_next = hc + 1'b1;
      vc_next = vc;
    end

    int_next = int_state;
    if (vc == LINE_VSYNC_LOW) begin
      if (hc == '0) begin
        int_next = 1'b0;
      end
      if (hc == COL_INT_END) begin
        int_next = 1'b1;
      end
    end

    if (vc == LINE_VSYNC_HIGH) begin
      nv = 1'b1;
    end else if (vc == LINE_VSYNC_LOW) begin
      nv = 1'b0;
    end else begin
      nv = vsync_state;
    end

    if (is_fetch) begin
      job_next.kind = SLOT_PIXEL;
    end else if (is_border) begin
      job_next.kind = SLOT_BORDER;
    end else begin
      job_next.kind = SLOT_NONE;
    end
    // Fetch and border windows both start on a multiple of 32 columns.
    job_next.group         = hc[4:0];
    job_next.bitmap        = test_bitmap;
    job_next.flash_on      = flash_count[4];
    job_next.buffer_select = active_buffer;
    job_next.line_trigger  = trig;
    job_next.int_level     = int_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc            <= '0;
      vc            <= '0;
      int_state     <= 1'b1;
      flash_count   <= '0;
      vsync_state   <= 1'b1;
      active_buffer <= 1'b0;
      test_bitmap   <= TEST_BITMAP_RESET;
      job_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        test_bitmap <= cfg.data.test_bitmap;
      end
      if (tick) begin
        hc          <= hc_next;
        vc          <= vc_next;
        int_state   <= int_next;
        vsync_state <= nv;
        if (vsync_state && !nv) begin
          flash_count <= flash_count + 1'b1;
        end
        if (trig) begin
          active_buffer <= !active_buffer;
        end
        job       <= job_next;
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/avrg_emit.sv
// Result sequencer: expands one job into its result transactions.
module avrg_emit
  import avrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  input  logic [7:0]  attr_rdata,
  avrg_chan_if.source dout
);

  job_t       cur;
  logic       cur_valid;
  logic [7:0] attr;
  logic [2:0] pos;

  logic       advance;
  logic       last_here;
  logic [2:0] pos_last;
  logic       pix;
  logic [3:0] colour;
  out_item_t  res;

  always_comb begin
    case (cur.kind)
      SLOT_PIXEL:  pos_last = 3'd7;
      SLOT_BORDER: pos_last = 3'd3;
      default:     pos_last = 3'd0;
    endcase
  end

  assign advance   = cur_valid && (!dout.valid || dout.ready);
  assign last_here = (pos == pos_last);
  assign job_take  = !cur_valid || (advance && last_here);

  // Most significant bitmap bit first; flash inverts the bit where attribute bit 7 is set.
  assign pix    = cur.bitmap[3'd7 - pos] ^ (attr[7] & cur.flash_on);
  assign colour = {attr[6], pix ? attr[2:0] : attr[5:3]};

  always_comb begin
    res               = '0;
    res.buffer_select = cur.buffer_select;
    res.line_trigger  = cur.line_trigger;
    res.int_level     = cur.int_level;
    res.last          = last_here;
    case (cur.kind)
      SLOT_PIXEL: begin
        res.slot_kind    = SLOT_PIXEL;
        res.word_index   = {1'b0, cur.group, pos};
        res.colour_index = colour;
        res.rgb_bits     = {colour[3], colour[0], colour[2], colour[1]};
      end
      SLOT_BORDER: begin
        // First half of the window carries border words, the rest template words.
        res.slot_kind  = cur.group[4] ? SLOT_TEMPLATE : SLOT_BORDER;
        res.word_index = BORDER_WORD_BASE + {2'b00, cur.group, pos[1:0]};
      end
      default: begin
        res.slot_kind = SLOT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pos        <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (job_take && job_valid) begin
        cur       <= job;
        attr      <= attr_rdata;
        pos       <= '0;
        cur_valid <= 1'b1;
      end else if (advance) begin
        pos <= pos + 1'b1;
        if (last_here) begin
          cur_valid <= 1'b0;
        end
      end

      if (advance) begin
        dout.valid <= 1'b1;
        dout.data  <= res;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

endmodule

// File: test/tb_attribute_video_raster_generator.sv
// Testbench of the attribute raster generator: raster sweep against a scoreboard predictor.
module tb_attribute_video_raster_generator;
  import avrg_pkg::*;

  // A small frame that still holds the trigger column and the vsync lines.
  localparam int unsigned TB_COLUMN_LAST = 320;
  localparam int unsigned TB_LINE_LAST   = 253;
  // Sweep line 0 from column 0 into the fetch window, through its first groups.
  localparam int unsigned FETCH_GROUPS   = 8;
  localparam int unsigned SWEEP_TICKS    = 256 + FETCH_GROUPS;
  localparam int unsigned SEGMENTS       = 4;
  localparam int unsigned SEG_TICKS      = SWEEP_TICKS / SEGMENTS;
  localparam int unsigned TEMPLATE_FIRST = 320;
  localparam int unsigned IDLE_PCT       = 26;
  localparam int unsigned HOLD_OFF       = 16;
  localparam int unsigned CYCLE_LIMIT    = 20000;

  class raster_scoreboard;
    out_item_t   words_due[$];
    logic [7:0]  bitmap;
    logic [8:0]  col_ctr;
    logic [8:0]  line_ctr;
    logic        int_lvl;
    logic [7:0]  flash_ctr;
    logic        vsync_lvl;
    logic        buf_sel;
    logic [7:0]  attr_mem [AVRG_ATTR_ENTRIES];
    int unsigned errors;
    int unsigned words_checked;
    int unsigned ticks;
    int unsigned fetch_ticks;
    int unsigned border_ticks;
    int unsigned attr_writes;

    function new();
      bitmap        = TEST_BITMAP_RESET;
      col_ctr       = '0;
      line_ctr      = '0;
      int_lvl       = 1'b1;
      flash_ctr     = '0;
      vsync_lvl     = 1'b1;
      buf_sel       = 1'b0;
      errors        = 0;
      words_checked = 0;
      ticks         = 0;
      fetch_ticks   = 0;
      border_ticks  = 0;
      attr_writes   = 0;
    endfunction

    function void queue_word(slot_kind_t kind, int unsigned widx, logic [3:0] colour,
                             logic trig, logic fin);
      out_item_t w;
      w.slot_kind     = kind;
      w.word_index    = widx[8:0];
      w.colour_index  = colour;
      w.rgb_bits      = {colour[3], colour[0], colour[2], colour[1]};
      w.buffer_select = buf_sel;
      w.line_trigger  = trig;
      w.int_level     = int_lvl;
      w.last          = fin;
      words_due.push_back(w);
    endfunction

    function void accept_item(in_item_t it);
      int unsigned g;
      int unsigned aidx;
      int unsigned base;
      logic [7:0]  attr;
      logic        flash;
      logic        pix;
      logic        trig;
      logic        nv;
      if (it.action == ACT_ATTR_WRITE) begin
        attr_writes++;
        // Drop writes past the end of the store.
        if (it.attr_addr < AVRG_ATTR_ENTRIES) attr_mem[it.attr_addr] = it.attr_data;
        return;
      end
      ticks++;
      trig = (col_ctr == COL_TRIGGER);
      if (col_ctr >= COL_FETCH_FIRST && col_ctr < COL_BORDER_FIRST && line_ctr < LINE_ACTIVE) begin
        fetch_ticks++;
        g     = col_ctr - COL_FETCH_FIRST;
        aidx  = (line_ctr / 8) * 32 + g;
        attr  = attr_mem[aidx];
        flash = attr[7] & flash_ctr[4];
        for (int p = 0; p < 8; p++) begin
          pix = bitmap[7 - p] ^ flash;
          queue_word(SLOT_PIXEL, g * 8 + unsigned'(p), {attr[6], pix ? attr[2:0] : attr[5:3]},
                     trig, p == 7);
        end
      end else if (col_ctr >= COL_BORDER_FIRST && col_ctr <= COL_TRIGGER) begin
        border_ticks++;
        base = BORDER_WORD_BASE + (col_ctr - COL_BORDER_FIRST) * 4;
        for (int i = 0; i < 4; i++)
          queue_word((base + i < TEMPLATE_FIRST) ? SLOT_BORDER : SLOT_TEMPLATE,
                     base + unsigned'(i), 4'd0, trig, i == 3);
      end else begin
        queue_word(SLOT_NONE, 0, 4'd0, trig, 1'b1);
      end

      if (trig) buf_sel = ~buf_sel;
      if (line_ctr == LINE_VSYNC_LOW) begin
        if (col_ctr == 0) int_lvl = 1'b0;
        if (col_ctr == COL_INT_END) int_lvl = 1'b1;
      end
      nv = (line_ctr == LINE_VSYNC_HIGH) ? 1'b1 : (line_ctr == LINE_VSYNC_LOW) ? 1'b0 : vsync_lvl;
      if (vsync_lvl && !nv) flash_ctr = flash_ctr + 8'd1;
      vsync_lvl = nv;
      if (col_ctr == TB_COLUMN_LAST) begin
        col_ctr  = '0;
        line_ctr = (line_ctr == TB_LINE_LAST) ? 9'd0 : line_ctr + 9'd1;
      end else begin
        col_ctr = col_ctr + 9'd1;
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      words_checked++;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: result with nothing expected: kind=%0d word=%0d colour=%0d", $time,
                   got.slot_kind, got.word_index, got.colour_index);
        return;
      end
      want = words_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display({"%0t: result mismatch: expected kind=%0d word=%0d colour=%0d rgb=%0d ",
                    "buf=%0b trig=%0b int=%0b last=%0b, actual kind=%0d word=%0d colour=%0d ",
                    "rgb=%0d buf=%0b trig=%0b int=%0b last=%0b"}, $time,
                   want.slot_kind, want.word_index, want.colour_index, want.rgb_bits,
                   want.buffer_select, want.line_trigger, want.int_level, want.last,
                   got.slot_kind, got.word_index, got.colour_index, got.rgb_bits,
                   got.buffer_select, got.line_trigger, got.int_level, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;
  int unsigned cycle_count;
  int unsigned settings;

  avrg_chan_if #(.T(in_item_t))  din_if ();
  avrg_chan_if #(.T(cfg_item_t)) cfg_if ();
  avrg_chan_if #(.T(out_item_t)) dout_if ();

  raster_scoreboard sb;

  attribute_video_raster_generator #(
    .COLUMN_LAST (TB_COLUMN_LAST),
    .LINE_LAST   (TB_LINE_LAST),
    .ATTR_ENTRIES(AVRG_ATTR_ENTRIES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .cfg (cfg_if),
    .dout(dout_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: stall at random, except during the calm stretch.
  initial begin
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      dout_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Sample every transaction at the edge it completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (din_if.valid && din_if.ready) sb.accept_item(din_if.data);
      if (cfg_if.valid && cfg_if.ready) sb.bitmap = cfg_if.data.test_bitmap;
      if (dout_if.valid && dout_if.ready) sb.check_word(dout_if.data);
    end
  end

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.data  <= it;
    do @(posedge clk); while (!din_if.ready);
  endtask

  initial begin
    in_item_t    it;
    int unsigned sent;
    logic [7:0]  val;
    sb            = new();
    calm          = 1'b0;
    settings      = 0;
    rst          <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill every entry the sweep reads before any fetch tick.
    for (int i = 0; i < FETCH_GROUPS; i++) begin
      it.action    = ACT_ATTR_WRITE;
      it.attr_addr = 10'(i);
      case (i)
        0:       it.attr_data = 8'h00;
        1:       it.attr_data = 8'hFF;
        2:       it.attr_data = 8'h07;
        3:       it.attr_data = 8'h38;
        4:       it.attr_data = 8'h40;
        default: it.attr_data = 8'($urandom_range(255));
      endcase
      send_item(it);
    end
    // Out-of-range addresses must not alias onto real entries.
    it.action = ACT_ATTR_WRITE;
    it.attr_addr = 10'd768;  it.attr_data = 8'hFF; send_item(it);
    it.attr_addr = 10'd1023; it.attr_data = 8'h81; send_item(it);
    it.attr_addr = 10'd769;  it.attr_data = 8'h5A; send_item(it);
    it.attr_addr = 10'd1000; it.attr_data = 8'hC3; send_item(it);

    // Sweep into the fetch window; retune the bitmap between segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg > 0) begin
        while (sb.words_due.size() != 0) @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        case (seg)
          1:       val = 8'h00;
          2:       val = 8'hFF;
          default: val = 8'($urandom_range(255));
        endcase
        cfg_if.valid            <= 1'b1;
        cfg_if.data.test_bitmap <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        settings++;
      end
      calm = (seg == 2);
      sent = 0;
      while (sent < SEG_TICKS) begin
        it.action    = ($urandom_range(31) == 0) ? ACT_ATTR_WRITE : ACT_TICK;
        it.attr_addr = ($urandom_range(1) == 0) ? 10'($urandom_range(FETCH_GROUPS - 1))
                                                : 10'($urandom_range(1023));
        it.attr_data = 8'($urandom_range(255));
        send_item(it);
        if (it.action == ACT_TICK) sent++;
      end
      din_if.valid <= 1'b0;
    end
    calm = 1'b0;

    while (sb.words_due.size() != 0) @(posedge clk);
    repeat (2 * HOLD_OFF) @(posedge clk);

    $display("Run covered %0d ticks (%0d in the fetch window), %0d attribute writes,",
             sb.ticks, sb.fetch_ticks, sb.attr_writes);
    $display("%0d bitmap settings; checked %0d result words, %0d errors.",
             settings + 1, sb.words_checked, sb.errors);
    if (sb.errors == 0 && sb.words_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/avrg_pkg.sv
sv/avrg_chan_if.sv
sv/avrg_ram.sv
sv/avrg_ctrl.sv
sv/avrg_emit.sv
sv/attribute_video_raster_generator.sv
test/tb_attribute_video_raster_generator.sv
